### rtl/cva_pkg.sv
package cva_pkg;

	localparam int CFG_W         = 11;
	localparam int SAMPLE_W      = 16;
	localparam int HEIGHT_W      = 18;
	localparam int CFG_IDX_W     = 1;
	localparam int IN_TDATA_W    = 16;
	localparam int OUT_TDATA_W   = 24;
	localparam int DEF_MAX_WIDTH = 1024;

	localparam logic [CFG_W-1:0] MAP_WIDTH_RST  = 11'd256;
	localparam logic [CFG_W-1:0] MAP_HEIGHT_RST = 11'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH  = 1'b0,
		REG_MAP_HEIGHT = 1'b1
	} reg_idx_t;

	// neighbor flags and end markers of one vertex position
	typedef struct packed {
		logic has_left;
		logic has_right;
		logic has_up;
		logic has_down;
		logic row_end;
		logic frame_end;
	} pos_t;

endpackage

### rtl/cell_to_vertex_average.sv
// path: an input beat is held in the stage 1 register and then in the output register as its result beat
// throughput: one vertex per cycle unless m_axis_tready stalls, set by the line store's one read and one write port
// reset: arst_n at once clears counters, neighbor samples and valid flags and loads the map size registers
// line store is not cleared: every entry whose sample is used is written one row earlier in the frame
module cell_to_vertex_average #(
	parameter int MAX_WIDTH = cva_pkg::DEF_MAX_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cva_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cva_pkg::CFG_W-1:0]        cfg_data,
	// cell samples in raster vertex order
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [cva_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [15:0] cell_sample
	// vertex heights
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [cva_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [17:0] vertex_height, rest zero
	output logic                             m_axis_tlast,  // row_end
	output logic                             m_axis_tuser   // [0] frame_end
);
	import cva_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	// stage 0: accept beat, issue line store read at the current column
	logic                 in_beat;
	pos_t                 pos;
	logic [AW-1:0]        addr;

	// stage 1: line store data valid, sum formed here
	logic                 s1_valid_q;
	logic                 s1_adv;
	pos_t                 pos_s1;
	logic [AW-1:0]        addr_s1;
	logic [SAMPLE_W-1:0]  cur_s1;
	logic [SAMPLE_W-1:0]  up_rd;
	logic [SAMPLE_W-1:0]  up_s1;
	logic                 wr_en;

	// samples of the vertex to the left
	logic [SAMPLE_W-1:0]  left_q;
	logic [SAMPLE_W-1:0]  upper_left_q;

	logic signed [HEIGHT_W-1:0] height_s1;

	// output register
	logic                 out_valid_q;
	logic [HEIGHT_W-1:0]  height_q;
	logic                 row_end_q;
	logic                 frame_end_q;

	assign cfg_ready = 1'b1;

	assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	cva_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (in_beat),
		.pos       (pos),
		.addr      (addr)
	);

	// write back the current cell where it lies inside the map
	assign wr_en = s1_adv && pos_s1.has_right && pos_s1.has_down;

	cva_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_store (
		.clk     (clk),
		.rd_en   (in_beat),
		.rd_addr (addr),
		.rd_data (up_rd),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (cur_s1)
	);

	// above sample counts only inside the map columns
	assign up_s1 = pos_s1.has_right ? up_rd : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_beat) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			pos_s1  <= pos;
			addr_s1 <= addr;
			cur_s1  <= s_axis_tdata[SAMPLE_W-1:0];
		end
	end

	// neighbor samples move on as each vertex leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
		end else if (s1_adv) begin
			left_q       <= cur_s1;
			upper_left_q <= up_s1;
		end
	end

	cva_sum u_sum (
		.pos        (pos_s1),
		.upper_left (upper_left_q),
		.left       (left_q),
		.up         (up_s1),
		.cur        (cur_s1),
		.height     (height_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			height_q    <= height_s1;
			row_end_q   <= pos_s1.row_end;
			frame_end_q <= pos_s1.frame_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(height_q);
	assign m_axis_tlast  = row_end_q;
	assign m_axis_tuser  = frame_end_q;

endmodule

### rtl/cva_line_store.sv
module cva_line_store #(
	parameter int MAX_WIDTH = cva_pkg::DEF_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [cva_pkg::SAMPLE_W-1:0]  rd_data,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [cva_pkg::SAMPLE_W-1:0]  wr_data
);
	import cva_pkg::*;

	logic [SAMPLE_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// write-first forwarding on a same-cycle hit
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end

endmodule

### rtl/cva_ctrl.sv
module cva_ctrl #(
	parameter int MAX_WIDTH = cva_pkg::DEF_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [cva_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cva_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           step,
	output cva_pkg::pos_t                  pos,
	output logic [AW-1:0]                  addr
);
	import cva_pkg::*;

	localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
	localparam int EW      = (CFG_W > MW_BITS) ? CFG_W : MW_BITS;

	logic [CFG_W-1:0]    map_width_q;
	logic [CFG_W-1:0]    map_height_q;
	logic [CFG_W-1:0]    col_q;
	logic [CFG_W-1:0]    row_q;
	logic [CFG_W-1:0]    w_eff;
	logic [CFG_W-1:0]    h_eff;
	logic [EW-1:0]       w_ext;
	logic [CFG_W+AW-1:0] col_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_WIDTH_RST;
			map_height_q <= MAP_HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAP_WIDTH:  map_width_q  <= cfg_data;
				REG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero means one, width saturates at the line store depth
	always_comb begin
		w_ext = EW'(map_width_q);
		if (map_width_q == '0) begin
			w_eff = CFG_W'(1);
		end else if (w_ext > EW'(MAX_WIDTH)) begin
			w_eff = CFG_W'(MAX_WIDTH);
		end else begin
			w_eff = map_width_q;
		end
		h_eff = (map_height_q == '0) ? CFG_W'(1) : map_height_q;
	end

	always_comb begin
		pos.has_left  = (col_q != '0);
		pos.has_right = (col_q < w_eff);
		pos.has_up    = (row_q != '0);
		pos.has_down  = (row_q < h_eff);
		pos.row_end   = !pos.has_right;
		pos.frame_end = !pos.has_right && !pos.has_down;
		col_ext       = {{AW{1'b0}}, col_q};
		addr          = col_ext[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (!pos.has_right) begin
				col_q <= '0;
				row_q <= pos.has_down ? row_q + CFG_W'(1) : '0;
			end else begin
				col_q <= col_q + CFG_W'(1);
			end
		end
	end

endmodule

### rtl/cva_sum.sv
module cva_sum (
	input  cva_pkg::pos_t                        pos,
	input  logic signed [cva_pkg::SAMPLE_W-1:0]  upper_left,
	input  logic signed [cva_pkg::SAMPLE_W-1:0]  left,
	input  logic signed [cva_pkg::SAMPLE_W-1:0]  up,
	input  logic signed [cva_pkg::SAMPLE_W-1:0]  cur,
	output logic signed [cva_pkg::HEIGHT_W-1:0]  height
);
	import cva_pkg::*;

	logic signed [HEIGHT_W-1:0] t_ul, t_l, t_u, t_c, sum;
	logic                       both_lr, both_ud;

	always_comb begin
		t_ul = (pos.has_left  && pos.has_up)   ? HEIGHT_W'(upper_left) : '0;
		t_l  = (pos.has_left  && pos.has_down) ? HEIGHT_W'(left)       : '0;
		t_u  = (pos.has_right && pos.has_up)   ? HEIGHT_W'(up)         : '0;
		t_c  = (pos.has_right && pos.has_down) ? HEIGHT_W'(cur)        : '0;
		sum  = t_ul + t_l + t_u + t_c;
		both_lr = pos.has_left && pos.has_right;
		both_ud = pos.has_up && pos.has_down;
		// four cells as is, two cells doubled, one cell times four
		if (both_lr && both_ud) begin
			height = sum;
		end else if (both_lr || both_ud) begin
			height = sum <<< 1;
		end else begin
			height = sum <<< 2;
		end
	end

endmodule

### rtl/cva_checker.sv
module cva_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_ready,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [cva_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic                             m_axis_tlast,
	input logic                             m_axis_tuser
);
	import cva_pkg::*;

	logic       in_beat;
	logic       out_beat;
	logic [1:0] pending_q;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// beats accepted whose result has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (pending_q != '0))
		else $error("result beat without an accepted input beat");

	a_frame_on_row: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
		else $error("frame end outside a row end");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:HEIGHT_W] == '0))
		else $error("tdata padding not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result beat changed");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> (!m_axis_tvalid && cfg_ready))
		else $error("output valid during reset");

endmodule

bind cell_to_vertex_average cva_checker u_cva_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_ready     (cfg_ready),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
